>>> rtl/swqt_pkg.sv
package swqt_pkg;

  // Operation codes on the func field
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_OUT    = 2'd2,
    FN_HEAD   = 2'd3
  } func_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_FIND   = 2'd1,
    S_UNLINK = 2'd2
  } state_e;

  // Queue end marks per process
  localparam logic [1:0] END_HEAD = 2'b01;
  localparam logic [1:0] END_TAIL = 2'b10;

endpackage

>>> rtl/swqt_in_if.sv
interface swqt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] sem_key;
  logic [4:0]  proc_index;
  logic        proc_present;

  modport source (output valid, func, sem_key, proc_index, proc_present, input ready);
  modport sink   (input valid, func, sem_key, proc_index, proc_present, output ready);
endinterface

>>> rtl/swqt_out_if.sv
interface swqt_out_if;
  logic       valid;
  logic       ready;
  logic       failed;
  logic [4:0] result_proc;
  logic       result_valid;

  modport source (output valid, failed, result_proc, result_valid, input ready);
  modport sink   (input valid, failed, result_proc, result_valid, output ready);
endinterface

>>> rtl/swqt_ram.sv
module swqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/semaphore_wait_queue_table.sv
// Semaphore wait-queue table. Each input transfer carries one operation
// (insert, remove head, out of queue, head peek) and yields exactly one result
// transfer. Descriptor keys sit in a match array that is compared combinationally
// against the latched key; queue links (next, prev) and each blocked process's
// descriptor index live in synchronous RAMs. Remove and out go through a match
// and RAM read state, then a link update state; insert, head and failures end in
// the match state. Each result is then offered from the output register. A new item
// is taken once the previous result has left the output register.
module semaphore_wait_queue_table import swqt_pkg::*; #(
  parameter int NUM_PROCS = 32,
  parameter int KEY_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swqt_in_if.sink     in_i,
  swqt_out_if.source  out_o
);

  localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  typedef logic [PW-1:0]       pidx_t;
  typedef logic [KEY_BITS-1:0] key_t;

  state_e state_q, state_d;

  // Latched item
  func_e func_q;
  key_t  key_q;
  pidx_t p_q;
  logic  have_q;
  pidx_t d_q;

  // Descriptor and process state in flops
  logic       in_use_q  [NUM_PROCS];
  key_t       dkey_q    [NUM_PROCS];
  pidx_t      head_q    [NUM_PROCS];
  pidx_t      tail_q    [NUM_PROCS];
  logic [1:0] ends_q    [NUM_PROCS];
  logic       blocked_q [NUM_PROCS];

  // Output register
  logic  out_valid_q, failed_q, rv_q;
  pidx_t rp_q;

  // RAM ports
  logic  nx_we, pv_we, ds_we;
  pidx_t nx_wa, pv_wa, ds_wa, nx_wd, pv_wd, ds_wd, rd_addr;
  pidx_t nx_rd, pv_rd, ds_rd;

  swqt_ram #(.WIDTH(PW), .DEPTH(NUM_PROCS)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd), .raddr_i(rd_addr), .rdata_o(nx_rd));
  swqt_ram #(.WIDTH(PW), .DEPTH(NUM_PROCS)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd), .raddr_i(rd_addr), .rdata_o(pv_rd));
  swqt_ram #(.WIDTH(PW), .DEPTH(NUM_PROCS)) u_desc (
    .clk_i, .we_i(ds_we), .waddr_i(ds_wa), .wdata_i(ds_wd), .raddr_i(rd_addr), .rdata_o(ds_rd));

  // Input decode
  logic        in_xfer, out_xfer;
  logic [63:0] key_ext;
  logic [31:0] pidx_ext;
  assign in_i.ready = (state_q == S_IDLE) && !out_valid_q;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;
  assign key_ext    = {32'd0, in_i.sem_key};
  assign pidx_ext   = 32'(in_i.proc_index);

  // Key match and free search over descriptors
  logic  hit, free_ok;
  pidx_t hit_idx, free_idx;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = NUM_PROCS - 1; i >= 0; i--) begin
      if (in_use_q[i] && dkey_q[i] == key_q) begin
        hit = 1'b1;
        hit_idx = PW'(i);
      end
      if (!in_use_q[i]) begin
        free_ok = 1'b1;
        free_idx = PW'(i);
      end
    end
  end

  // Decisions in the match cycle
  logic  key_ok, ins_ok, to_unlink;
  pidx_t ins_d, t_idx, u_d, u_n, u_pr;
  logic [1:0] u_ends;
  assign key_ok    = key_q != '0;
  assign ins_ok    = key_ok && have_q && !blocked_q[p_q] && (hit || free_ok);
  assign ins_d     = hit ? hit_idx : free_idx;
  assign t_idx     = tail_q[hit_idx];
  assign to_unlink = ((func_q == FN_REMOVE) && key_ok && hit) ||
                     ((func_q == FN_OUT) && have_q && blocked_q[p_q]);
  assign rd_addr   = (func_q == FN_REMOVE) ? head_q[hit_idx] : p_q;
  assign u_d       = (func_q == FN_OUT) ? ds_rd : d_q;
  assign u_ends    = ends_q[p_q];
  assign u_n       = nx_rd;
  assign u_pr      = pv_rd;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_FIND;
      S_FIND:   state_d = to_unlink ? S_UNLINK : S_IDLE;
      S_UNLINK: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // RAM write controls
  always_comb begin
    nx_we = 1'b0; nx_wa = t_idx; nx_wd = p_q;
    pv_we = 1'b0; pv_wa = p_q;   pv_wd = t_idx;
    ds_we = 1'b0; ds_wa = p_q;   ds_wd = ins_d;
    case (state_q)
      S_FIND: begin
        if (func_q == FN_INSERT && ins_ok) begin
          ds_we = 1'b1;
          nx_we = hit;
          pv_we = hit;
        end
      end
      S_UNLINK: begin
        if (u_ends == 2'b00) begin
          nx_we = 1'b1; nx_wa = u_pr; nx_wd = u_n;
          pv_we = 1'b1; pv_wa = u_n;  pv_wd = u_pr;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_PROCS; i++) begin
        in_use_q[i]  <= 1'b0;
        blocked_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (out_xfer) out_valid_q <= 1'b0;
      if ((state_q == S_FIND && !to_unlink) || state_q == S_UNLINK) out_valid_q <= 1'b1;
      if (state_q == S_FIND && func_q == FN_INSERT && ins_ok) begin
        blocked_q[p_q] <= 1'b1;
        if (!hit) in_use_q[free_idx] <= 1'b1;
      end
      if (state_q == S_UNLINK) begin
        blocked_q[p_q] <= 1'b0;
        if (u_ends == (END_HEAD | END_TAIL)) in_use_q[u_d] <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q <= func_e'(in_i.func);
      key_q  <= key_ext[KEY_BITS-1:0];
      p_q    <= pidx_ext[PW-1:0];
      have_q <= in_i.proc_present && (pidx_ext < 32'(NUM_PROCS));
    end
    case (state_q)
      S_FIND: begin
        failed_q <= 1'b1;
        rv_q     <= 1'b0;
        rp_q     <= '0;
        if (func_q == FN_REMOVE) begin
          p_q <= head_q[hit_idx];
          d_q <= hit_idx;
        end
        if (func_q == FN_HEAD && key_ok && hit) begin
          failed_q <= 1'b0;
          rv_q     <= 1'b1;
          rp_q     <= head_q[hit_idx];
        end
        if (func_q == FN_INSERT && ins_ok) begin
          failed_q <= 1'b0;
          if (hit) begin
            ends_q[t_idx]   <= ends_q[t_idx] & ~END_TAIL;
            ends_q[p_q]     <= END_TAIL;
            tail_q[hit_idx] <= p_q;
          end else begin
            dkey_q[free_idx] <= key_q;
            head_q[free_idx] <= p_q;
            tail_q[free_idx] <= p_q;
            ends_q[p_q]      <= END_HEAD | END_TAIL;
          end
        end
      end
      S_UNLINK: begin
        failed_q <= 1'b0;
        rv_q     <= 1'b1;
        rp_q     <= p_q;
        if (u_ends == END_HEAD) begin
          head_q[u_d] <= u_n;
          ends_q[u_n] <= ends_q[u_n] | END_HEAD;
        end else if (u_ends == END_TAIL) begin
          tail_q[u_d]  <= u_pr;
          ends_q[u_pr] <= ends_q[u_pr] | END_TAIL;
        end
        ends_q[p_q] <= 2'b00;
      end
      default: ;
    endcase
  end

  // Output drive
  logic [31:0] rp_ext;
  assign rp_ext             = 32'(rp_q);
  assign out_o.valid        = out_valid_q;
  assign out_o.failed       = failed_q;
  assign out_o.result_valid = rv_q;
  assign out_o.result_proc  = rv_q ? rp_ext[4:0] : 5'd0;

  // Checks
  logic [NUM_PROCS-1:0] use_vec, blk_vec;
  always_comb begin
    for (int i = 0; i < NUM_PROCS; i++) begin
      use_vec[i] = in_use_q[i];
      blk_vec[i] = blocked_q[i];
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_FIND) else $error("accept outside idle");
  a_insert_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND && func_q == FN_INSERT && ins_ok) |=> blocked_q[$past(p_q)])
    else $error("insert did not block process");
  a_desc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(use_vec) <= $countones(blk_vec)) else $error("descriptor without process");
  a_result_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UNLINK |=> out_valid_q && !failed_q && rv_q) else $error("unlink lost result");

endmodule
